// File: hdl/dkc_pkg.sv
// ----------------------------------------------------------------------------
// dkc_pkg
// Shared constants for the distinct k-mer counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dkc_pkg;

    localparam int MAX_KMER_DEF = 8;
    localparam int EPOCH_W_DEF  = 8;

    localparam int CFG_W   = 4;
    localparam int BASE_W  = 2;
    localparam int COUNT_W = 17;

    localparam logic [CFG_W-1:0] KMER_LENGTH_RESET = 4'd4;

endpackage

`default_nettype wire

// File: hdl/dkc_ram.sv
// ----------------------------------------------------------------------------
// dkc_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/distinct_kmer_counter.sv
// A sequence's last base passes the stage-0 registers, then its count is offered from
// the result queue. Throughput: one base per cycle unless o_stall, set by the single
// read-modify-write of the bitmap RAM; a three-entry result queue keeps bases flowing
// while counts leave one per cycle unless i_stall. Reset: a clearing pass writes all
// 4**MAX_KMER RAM entries (65536 by default); the same pass runs after every
// 2**EPOCH_W-1 sequences. No base is taken in the pass, but kmer_length writes are.
// ----------------------------------------------------------------------------
// distinct_kmer_counter
// Counts distinct k-mers of a base stream with an epoch-tagged bitmap RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_kmer_counter
    import dkc_pkg::*;
#(
    parameter int MAX_KMER = MAX_KMER_DEF,
    parameter int EPOCH_W  = EPOCH_W_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_kmer_length_we,
    input  wire logic [CFG_W-1:0]   i_kmer_length,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [BASE_W-1:0]  i_base,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [COUNT_W-1:0] o_distinct_count
);

    localparam int AW    = 2 * MAX_KMER;
    localparam int DEPTH = 1 << AW;
    localparam int BW    = $clog2(MAX_KMER + 1);

    typedef enum logic {
        S_CLEAR,
        S_RUN
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_kmer_length;
    logic [AW-1:0]       r_window;
    logic [BW-1:0]       r_bases;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [AW-1:0]       r_clr_addr;
    logic                r_s1_valid;
    logic                r_s1_last;
    logic                r_s1_check;
    logic [AW-1:0]       r_s1_idx;
    logic                r_p_valid;
    logic [AW-1:0]       r_p_idx;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  r_q [3];
    logic [1:0]          r_wp;
    logic [1:0]          r_rp;
    logic [1:0]          r_cnt;

    logic [CFG_W-1:0]    k_eff;
    logic [AW-1:0]       k_mask;
    logic [AW-1:0]       n_window;
    logic [BW-1:0]       n_bases;
    logic                n_check;
    logic                accept;
    logic                wrap;
    logic                seen;
    logic                mark;
    logic                push;
    logic                pop;
    logic [COUNT_W-1:0]  n_count;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EPOCH_W-1:0]  ram_wdata;
    logic [EPOCH_W-1:0]  ram_rdata;

    // effective k and the mask of its window
    always_comb begin
        if (r_kmer_length == '0) begin
            k_eff = CFG_W'(1);
        end else if (r_kmer_length > CFG_W'(MAX_KMER)) begin
            k_eff = CFG_W'(MAX_KMER);
        end else begin
            k_eff = r_kmer_length;
        end
        for (int i = 0; i < MAX_KMER; i++) begin
            k_mask[2*i +: 2] = (CFG_W'(i) < k_eff) ? 2'b11 : 2'b00;
        end
    end

    assign n_window = (r_window << 2) | AW'(i_base);
    assign n_bases  = (r_bases == BW'(MAX_KMER)) ? r_bases : r_bases + 1'b1;
    assign n_check  = CFG_W'(n_bases) >= k_eff;

    assign push = r_s1_valid && r_s1_last;
    assign wrap = push && (r_epoch == '1);
    assign pop  = (r_cnt != 2'd0) && !i_stall;

    assign o_stall = (r_state != S_RUN) || wrap || (r_cnt == 2'd3)
                     || ((r_cnt == 2'd2) && push);
    assign accept  = i_valid && !o_stall;

    // hit check with forwarding from the previous mark
    assign seen = (ram_rdata == r_epoch) || (r_p_valid && (r_p_idx == r_s1_idx));
    assign mark = r_s1_valid && r_s1_check && !seen;

    always_comb begin
        n_count = r_count;
        if (mark && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = mark;
            ram_waddr = r_s1_idx;
            ram_wdata = r_epoch;
        end
    end

    dkc_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_window & k_mask),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_kmer_length <= KMER_LENGTH_RESET;
            r_window      <= '0;
            r_bases       <= '0;
            r_epoch       <= EPOCH_W'(1);
            r_clr_addr    <= '0;
            r_s1_valid    <= 1'b0;
            r_s1_last     <= 1'b0;
            r_s1_check    <= 1'b0;
            r_p_valid     <= 1'b0;
            r_count       <= '0;
            r_wp          <= 2'd0;
            r_rp          <= 2'd0;
            r_cnt         <= 2'd0;
        end else begin
            if (i_kmer_length_we) begin
                r_kmer_length <= i_kmer_length;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= S_RUN;
                        r_epoch <= EPOCH_W'(1);
                    end
                end
                S_RUN: begin
                    if (wrap) begin
                        r_state <= S_CLEAR;
                    end else if (push) begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase

            // stage 0: window update and RAM read
            r_s1_valid <= accept;
            if (accept) begin
                r_s1_last  <= i_last;
                r_s1_check <= n_check;
                r_s1_idx   <= n_window & k_mask;
                r_window   <= i_last ? '0 : n_window;
                r_bases    <= i_last ? '0 : n_bases;
            end

            // stage 1: mark and count
            r_p_valid <= r_s1_valid && r_s1_check && !r_s1_last;
            r_p_idx   <= r_s1_idx;
            if (r_s1_valid) begin
                r_count <= push ? '0 : n_count;
            end

            // result queue
            if (push) begin
                r_q[r_wp] <= n_count;
                r_wp      <= (r_wp == 2'd2) ? 2'd0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == 2'd2) ? 2'd0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_valid          = r_cnt != 2'd0;
    assign o_distinct_count = r_q[r_rp];

    a_wrap_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wrap |=> (r_state == S_CLEAR))
        else $error("epoch wrap did not start a clearing pass");

    a_no_work_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == S_RUN))
        else $error("item in flight during clearing pass");

    a_queue_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((r_cnt != 2'd3) || pop))
        else $error("result queue overflow");

    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("result queue pointers out of step");

    a_epoch_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_epoch != '0))
        else $error("live epoch equals cleared tag");

endmodule

`default_nettype wire

// File: dv/distinct_kmer_counter_tb.sv
// ----------------------------------------------------------------------------
// distinct_kmer_counter_tb
// Streams DNA bases into the distinct k-mer counter and checks each sequence
// count against an in-bench predictor or a directed table, which covers short
// sequences, out-of-range lengths and a length change mid-sequence. Random
// sequences then follow, with random idling on both channels and enough
// sequences to run past the bitmap epoch wrap and its clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module distinct_kmer_counter_tb
    import dkc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_W          = 2 * MAX_KMER_DEF;
    localparam int BASES_TARGET   = 1625;
    localparam int CALM_FROM      = BASES_TARGET - 200;
    localparam int WATCHDOG_LIMIT = 4 * (4 ** MAX_KMER_DEF);
    localparam int SETTLE_CYCLES  = 4;

    localparam logic [BASE_W-1:0] BASE_A = 2'd0;
    localparam logic [BASE_W-1:0] BASE_C = 2'd1;
    localparam logic [BASE_W-1:0] BASE_G = 2'd2;
    localparam logic [BASE_W-1:0] BASE_T = 2'd3;

    typedef enum logic {ROW_BASE, ROW_SET_K} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic [BASE_W-1:0]   base;
        logic                last;
        logic [CFG_W-1:0]    k_value;
        bit                  known;
        logic [COUNT_W-1:0]  count;
    } t_stim_row;

    t_stim_row directed_rows [0:30] = '{
        '{ROW_BASE,  BASE_A, 1'b1, 4'd0,  1'b1, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b1, 4'd0,  1'b1, 17'd1},
        '{ROW_SET_K, BASE_A, 1'b0, 4'd1,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_A, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_C, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_G, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b1, 4'd0,  1'b1, 17'd4},
        '{ROW_SET_K, BASE_A, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_G, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_G, 1'b1, 4'd0,  1'b1, 17'd1},
        '{ROW_SET_K, BASE_A, 1'b0, 4'd15, 1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_T, 1'b1, 4'd0,  1'b1, 17'd1},
        '{ROW_SET_K, BASE_A, 1'b0, 4'd8,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_C, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_A, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_G, 1'b1, 4'd0,  1'b1, 17'd0},
        '{ROW_SET_K, BASE_A, 1'b0, 4'd2,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_A, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_C, 1'b0, 4'd0,  1'b0, 17'd0},
        '{ROW_SET_K, BASE_A, 1'b0, 4'd1,  1'b0, 17'd0},
        '{ROW_BASE,  BASE_G, 1'b1, 4'd0,  1'b0, 17'd0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_kmer_length_we;
    logic [CFG_W-1:0]   i_kmer_length;
    logic               i_valid;
    logic               o_stall;
    logic [BASE_W-1:0]  i_base;
    logic               i_last;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [COUNT_W-1:0] o_distinct_count;

    // predictor state
    logic [CFG_W-1:0]   model_k;
    logic [WIN_W-1:0]   model_window;
    int unsigned        model_filled;
    logic [COUNT_W-1:0] model_total;
    bit                 model_marks [int unsigned];

    logic [COUNT_W-1:0] count_q [$];

    int unsigned fail_count     = 0;
    int unsigned bases_sent     = 0;
    int unsigned sequences_sent = 0;
    int unsigned counts_checked = 0;
    int unsigned k_settings     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned stall_left     = 0;
    int unsigned gap_pct        = 20;
    int unsigned stall_pct      = 20;
    bit          calm           = 1'b0;

    distinct_kmer_counter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kmer_length_we (i_kmer_length_we),
        .i_kmer_length    (i_kmer_length),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_base           (i_base),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_distinct_count (o_distinct_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_model_sequence();
        model_window = '0;
        model_filled = 0;
        model_total  = '0;
        model_marks.delete();
    endfunction

    // advances the k-mer state by one base, returns 1 when a count is due
    function automatic bit count_distinct(input logic [BASE_W-1:0] b, input logic l,
                                          output logic [COUNT_W-1:0] count);
        int unsigned k;
        int unsigned key;
        k = (model_k == 0) ? 1 : ((model_k > MAX_KMER_DEF) ? MAX_KMER_DEF : model_k);
        model_window = {model_window[WIN_W-3:0], b};
        if (model_filled < MAX_KMER_DEF)
            model_filled++;
        if (model_filled >= k) begin
            key = model_window & ((32'd1 << (2 * k)) - 1);
            if (!model_marks.exists(key)) begin
                model_marks[key] = 1'b1;
                if (model_total != '1)
                    model_total++;
            end
        end
        count = model_total;
        if (l)
            clear_model_sequence();
        return l;
    endfunction

    task automatic send_base(input logic [BASE_W-1:0] b, input logic l, input bit known,
                             input logic [COUNT_W-1:0] known_count);
        logic [COUNT_W-1:0] predicted;
        int unsigned gap;
        if (!calm && $urandom_range(1, 100) <= gap_pct) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) begin
                i_base <= BASE_W'($urandom);
                i_last <= 1'($urandom);
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_base  <= b;
        i_last  <= l;
        do @(posedge i_clk); while (o_stall);
        bases_sent++;
        if (count_distinct(b, l, predicted)) begin
            count_q.push_back(known ? known_count : predicted);
            sequences_sent++;
        end
    endtask

    task automatic set_kmer_length(input logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (count_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_kmer_length_we <= 1'b1;
        i_kmer_length    <= v;
        @(posedge i_clk);
        i_kmer_length_we <= 1'b0;
        model_k = v;
        k_settings++;
    endtask

    task automatic send_sequence(input int unsigned len, input bit close);
        int unsigned style;
        int unsigned period;
        logic [BASE_W-1:0] motif [4];
        logic [BASE_W-1:0] b;
        style  = $urandom_range(0, 2);
        period = $urandom_range(1, 4);
        foreach (motif[m])
            motif[m] = BASE_W'($urandom);
        for (int unsigned n = 0; n < len; n++) begin
            case (style)
                0: b = BASE_W'($urandom);
                1: b = $urandom_range(0, 1) ? motif[0] : motif[1];
                default: b = motif[n % period];
            endcase
            send_base(b, close && (n == len - 1), 1'b0, '0);
        end
    endtask

    function automatic int unsigned pick_length();
        return ($urandom_range(1, 10) == 1) ? $urandom_range(9, 40) : $urandom_range(1, 6);
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    initial begin
        int unsigned phase;
        logic [CFG_W-1:0] k_pick;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_base           = '0;
        i_last           = 1'b0;
        i_kmer_length_we = 1'b0;
        i_kmer_length    = KMER_LENGTH_RESET;
        model_k          = KMER_LENGTH_RESET;
        clear_model_sequence();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_SET_K)
                set_kmer_length(directed_rows[r].k_value);
            else
                send_base(directed_rows[r].base, directed_rows[r].last,
                          directed_rows[r].known, directed_rows[r].count);
        end

        phase = 0;
        while (bases_sent < BASES_TARGET) begin
            case (phase)
                0: k_pick = 4'd1;
                1: k_pick = 4'd8;
                2: k_pick = 4'd0;
                3: k_pick = 4'd15;
                default: k_pick = CFG_W'($urandom_range(0, 15));
            endcase
            set_kmer_length(k_pick);
            gap_pct   = pick_idle_pct();
            stall_pct = pick_idle_pct();
            repeat ($urandom_range(2, 10))
                send_sequence(pick_length(), 1'b1);
            // leave a sequence open across the next length change
            if ($urandom_range(0, 3) == 0)
                send_sequence($urandom_range(1, 5), 1'b0);
            calm = (bases_sent >= CALM_FROM);
            phase++;
        end
        send_sequence(pick_length(), 1'b1);
        i_valid <= 1'b0;

        while (count_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("summary: %0d bases in %0d sequences across %0d length settings",
                 bases_sent, sequences_sent, k_settings);
        $display("summary: %0d counts checked, %0d mismatches", counts_checked, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if ($urandom_range(1, 100) <= stall_pct) begin
            stall_left <= $urandom_range(1, 5);
            i_stall    <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : count_check
        logic [COUNT_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (count_q.size() == 0) begin
                $error("distinct_count: no count expected, got %0d", o_distinct_count);
                fail_count++;
            end else begin
                want = count_q.pop_front();
                counts_checked++;
                if (o_distinct_count !== want) begin
                    $error("distinct_count: expected %0d, got %0d", want, o_distinct_count);
                    fail_count++;
                end
            end
        end
    end

    // covers the clearing pass after reset and at each epoch wrap
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire
